// ===== rtl/multihash_frame_parser_macros.svh =====
// Assertion helpers shared by the multihash frame parser modules.
// Define ASSERT_OFF to compile every check down to nothing.
`ifndef MULTIHASH_FRAME_PARSER_MACROS_SVH
`define MULTIHASH_FRAME_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define MHFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define MHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/mhfp_pkg.sv =====
`timescale 1ns / 1ps

package mhfp_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [2:0] K_CODE     = 3'd0;
    localparam logic [2:0] K_LEN      = 3'd1;
    localparam logic [2:0] K_DIGEST   = 3'd2;
    localparam logic [2:0] K_TRUNC    = 3'd3;
    localparam logic [2:0] K_OVERLONG = 3'd4;

    // A varint whose byte number MAX_VARINT_BYTES still continues is overlong.
    localparam logic [3:0] MAX_VARINT_BYTES = 4'd10;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        last;
    } t_result;

    // Up to two results produced by one parsed byte.
    typedef struct packed {
        t_result    res0;
        t_result    res1;
        logic [1:0] cnt;
    } t_parse_out;

endpackage

// ===== rtl/mhfp_parse.sv =====
`timescale 1ns / 1ps
`include "multihash_frame_parser_macros.svh"

module mhfp_parse import mhfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_parse_out o_out
);

    localparam logic [1:0] PH_CODE   = 2'd0;
    localparam logic [1:0] PH_LEN    = 2'd1;
    localparam logic [1:0] PH_DIGEST = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // Groups at byte index ten and above would land beyond bit 63.
    localparam logic [3:0] SHIFT_IDX_LIMIT = 4'd10;
    localparam logic [3:0] IDX_SAT         = 4'd15;

    logic [1:0]  r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_idx, n_idx;
    logic [63:0] r_rem, n_rem;

    logic [6:0]  sh;
    logic [63:0] shifted;
    logic [63:0] acc_or;
    logic [3:0]  idx_inc;
    logic [63:0] rem_dec;
    t_result     trunc_res;
    t_parse_out  out_c;

    // Seven-bit group placed at 7 * index, dropped once past the word.
    assign sh      = {r_idx, 3'b000} - {3'b000, r_idx};
    assign shifted = (r_idx < SHIFT_IDX_LIMIT) ? ({57'd0, i_byte[6:0]} << sh) : 64'd0;
    assign acc_or  = r_acc | shifted;
    assign idx_inc = (r_idx < IDX_SAT) ? (r_idx + 4'd1) : r_idx;
    assign rem_dec = r_rem - 64'd1;

    assign trunc_res = '{kind: K_TRUNC, value: 64'd0, last: 1'b1};

    // Next state and the results of the byte in the input register.
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_rem   = r_rem;
        out_c   = '0;
        if (r_phase inside {PH_CODE, PH_LEN}) begin
            n_acc = acc_or;
            n_idx = idx_inc;
            if (i_byte[7]) begin
                if (idx_inc >= MAX_VARINT_BYTES) begin
                    out_c.res0 = '{kind: K_OVERLONG, value: 64'd0, last: 1'b1};
                    out_c.cnt  = 2'd1;
                    n_phase    = PH_SKIP;
                end else if (i_end) begin
                    out_c.res0 = trunc_res;
                    out_c.cnt  = 2'd1;
                end
            end else if (r_phase == PH_CODE) begin
                out_c.res0 = '{kind: K_CODE, value: acc_or, last: 1'b0};
                out_c.cnt  = 2'd1;
                if (i_end) begin
                    out_c.res1 = trunc_res;
                    out_c.cnt  = 2'd2;
                end
                n_phase = PH_LEN;
                n_acc   = 64'd0;
                n_idx   = 4'd0;
            end else begin
                out_c.res0 = '{kind: K_LEN, value: acc_or, last: (acc_or == 64'd0)};
                out_c.cnt  = 2'd1;
                if (acc_or == 64'd0) begin
                    n_phase = PH_SKIP;
                end else begin
                    if (i_end) begin
                        out_c.res1 = trunc_res;
                        out_c.cnt  = 2'd2;
                    end
                    n_phase = PH_DIGEST;
                    n_rem   = acc_or;
                end
                n_acc = 64'd0;
                n_idx = 4'd0;
            end
        end else begin
            case (r_phase)
                PH_DIGEST: begin
                    n_rem      = rem_dec;
                    out_c.res0 = '{kind: K_DIGEST, value: {56'd0, i_byte},
                                   last: (rem_dec == 64'd0)};
                    out_c.cnt  = 2'd1;
                    if (rem_dec == 64'd0) begin
                        n_phase = PH_SKIP;
                    end else if (i_end) begin
                        out_c.res1 = trunc_res;
                        out_c.cnt  = 2'd2;
                    end
                end
                default: begin
                    // Skipping trailing bytes until the string ends.
                    n_phase = r_phase;
                end
            endcase
        end
        // The last byte of a string returns everything to the start.
        if (i_end) begin
            n_phase = PH_CODE;
            n_acc   = 64'd0;
            n_idx   = 4'd0;
            n_rem   = 64'd0;
        end
        if (!i_valid) begin
            out_c.cnt = 2'd0;
        end
    end

    assign o_out = out_c;

    // Parser state advances only on a byte that is handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_acc   <= 64'd0;
            r_idx   <= 4'd0;
            r_rem   <= 64'd0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
            r_rem   <= n_rem;
        end
    end

    `MHFP_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, i_valid && i_end,
        r_phase == PH_CODE && r_idx == 4'd0 && r_acc == 64'd0,
        "parser state not cleared after end of string")
    `MHFP_ASSERT_IMPL(a_second_is_trunc, i_clk, i_rst_n, o_out.cnt == 2'd2,
        o_out.res1.kind == K_TRUNC && o_out.res1.last && !o_out.res0.last,
        "second result of a byte must be a truncation closing the frame")

endmodule

// ===== rtl/mhfp_out_fifo.sv =====
`timescale 1ns / 1ps
`include "multihash_frame_parser_macros.svh"

module mhfp_out_fifo import mhfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_parse_out i_push,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_data
);

    localparam int unsigned DEPTH = 4;

    t_result    mem [DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [1:0] wr_ptr_p1;
    logic       rd;

    assign wr_ptr_p1 = r_wr_ptr + 2'd1;
    assign rd        = o_valid && i_ready;
    assign o_valid   = (r_count != 3'd0);
    assign o_data    = mem[r_rd_ptr];
    // Room for the worst case of two results from one byte.
    assign o_room    = (r_count <= 3'(DEPTH - 2));

    // Result storage, up to two writes per cycle.
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            mem[wr_ptr_p1] <= i_push.res1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.cnt;
            r_rd_ptr <= r_rd_ptr + {1'b0, rd};
            r_count  <= r_count + {1'b0, i_push.cnt} - {2'b00, rd};
        end
    end

    `MHFP_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push.cnt != 2'd0,
        r_count + {1'b0, i_push.cnt} <= 3'(DEPTH),
        "result queue overflow")
    `MHFP_ASSERT_NEXT(a_count_tracks, i_clk, i_rst_n, i_push.cnt != 2'd0 && !rd,
        r_count == $past(r_count) + {1'b0, $past(i_push.cnt)},
        "fill level does not follow the writes")

endmodule

// ===== rtl/multihash_frame_parser.sv =====
`timescale 1ns / 1ps
`include "multihash_frame_parser_macros.svh"

// Multihash frame parser.
// The slave stream carries the raw bytes of serialized multihash strings, one
// byte per request in tdata, with tlast on the final byte of each string. The
// master stream returns the parsed frame: the hash code, the digest length and
// then each digest byte, with the result kind in tuser and the value in tdata.
// tlast marks the final result of a frame; a truncation or overlong varint
// error is reported as a kind of its own with a zero value and tlast set.
// An accepted byte goes through the input register and the result queue to the
// master side. One byte is accepted every cycle while the receiver takes
// results and each byte yields at most one; a byte ending a string early can
// yield two, which leave via the four-entry result queue. A stalled receiver
// fills that queue and then the input register, after which tready drops.
// Reset clears the parser to the start of a frame and empties the queue;
// bytes after a complete frame are dropped until the end of the string.
module multihash_frame_parser import mhfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] value
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       accept;
    logic       advance;
    logic       room;
    t_parse_out parse_out;
    t_result    out_res;

    assign advance         = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    mhfp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_out   (parse_out)
    );

    mhfp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (parse_out),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_res)
    );

    assign o_m_axis_tdata = out_res.value;
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

    `MHFP_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, !o_s_axis_tready,
        r_in_valid && !room,
        "input stalled while the input register could move")

endmodule
